>>> src/ofbf_pkg.sv
// package: shared constants, control structs and message tables of the frame flush engine
`default_nettype none
package ofbf_pkg;

    localparam int WIDTH       = 128;
    localparam int PAGES       = 8;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int COL_W       = $clog2(WIDTH);
    localparam int PAGE_W      = $clog2(PAGES);
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int SUB_W       = 8;
    localparam int SETUP_LEN   = 27;
    localparam int WINDOW_LEN  = 7;

    localparam logic [2:0] OP_PIXEL   = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_INIT    = 3'd2;
    localparam logic [2:0] OP_PRESENT = 3'd3;
    localparam logic [2:0] OP_NEXT    = 3'd4;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_INIT    = 2'd1;
    localparam logic [1:0] MODE_PRESENT = 2'd2;

    localparam logic [7:0] DATA_PREFIX = 8'h40;
    localparam logic [6:0] ADDR_MIN    = 7'd3;
    localparam logic [6:0] ADDR_MAX    = 7'd119;
    localparam logic [6:0] ADDR_RESET  = 7'd60;

    typedef struct packed {
        logic pix_rd;
        logic pix_wr;
        logic pop_rd;
        logic pop_emit;
        logic sweep_clr;
        logic sweep_wr;
        logic start_init;
        logic start_present;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic addr_ok;
        logic sweep_last;
    } t_dp_stat;

    function automatic logic [7:0] setup_byte(input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:  b = 8'h00;
            5'd1:  b = 8'hae;
            5'd2:  b = 8'hd5;
            5'd3:  b = 8'h80;
            5'd4:  b = 8'ha8;
            5'd5:  b = 8'h3f;
            5'd6:  b = 8'hd3;
            5'd7:  b = 8'h00;
            5'd8:  b = 8'h40;
            5'd9:  b = 8'h8d;
            5'd10: b = 8'h14;
            5'd11: b = 8'h20;
            5'd12: b = 8'h00;
            5'd13: b = 8'ha1;
            5'd14: b = 8'hc8;
            5'd15: b = 8'hda;
            5'd16: b = 8'h12;
            5'd17: b = 8'h81;
            5'd18: b = 8'hcf;
            5'd19: b = 8'hd9;
            5'd20: b = 8'hf1;
            5'd21: b = 8'hdb;
            5'd22: b = 8'h40;
            5'd23: b = 8'ha4;
            5'd24: b = 8'ha6;
            5'd25: b = 8'h2e;
            default: b = 8'haf;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] window_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h00;
            3'd1: b = 8'h21;
            3'd2: b = 8'h00;
            3'd3: b = 8'(WIDTH - 1);
            3'd4: b = 8'h22;
            3'd5: b = 8'h00;
            default: b = 8'(PAGES - 1);
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

>>> src/ofbf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module ofbf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> src/ofbf_ctrl.sv
// controller: sequences pixel updates, byte pops and store sweeps
`default_nettype none
module ofbf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        i_operation,
    input  wire ofbf_pkg::t_dp_stat i_stat,
    output ofbf_pkg::t_dp_cmd      o_cmd,
    output logic                   busy
);
    import ofbf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_PIX   = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.active) begin
                        // only next byte is honored while a stream runs
                        if (i_operation == OP_NEXT) begin
                            o_cmd.pop_rd = 1'b1;
                            n_state      = S_POP;
                        end
                    end else begin
                        unique case (i_operation)
                            OP_PIXEL: begin
                                o_cmd.pix_rd = 1'b1;
                                n_state      = S_PIX;
                            end
                            OP_CLEAR: begin
                                o_cmd.sweep_clr = 1'b1;
                                n_state         = S_SWEEP;
                            end
                            OP_INIT: begin
                                if (i_stat.addr_ok) begin
                                    o_cmd.start_init = 1'b1;
                                    o_cmd.sweep_clr  = 1'b1;
                                    n_state          = S_SWEEP;
                                end
                            end
                            OP_PRESENT: begin
                                o_cmd.start_present = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_PIX: begin
                o_cmd.pix_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_POP: begin
                o_cmd.pop_emit = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // reset enters the sweep so the store starts out zeroed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> src/ofbf_dp.sv
// datapath: frame store, stream position, message framing and result registers
`default_nettype none
module ofbf_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ofbf_pkg::t_dp_cmd i_cmd,
    output ofbf_pkg::t_dp_stat     o_stat,
    input  wire logic              i_cfg_we,
    input  wire logic [6:0]        i_cfg_wdata,
    input  wire logic [7:0]        i_column,
    input  wire logic [7:0]        i_row,
    input  wire logic              i_pixel_on,
    output logic                   o_result_strobe,
    output logic [7:0]             o_data_byte,
    output logic [6:0]             o_bus_address,
    output logic                   o_message_start,
    output logic                   o_message_end,
    output logic                   o_stream_end
);
    import ofbf_pkg::*;

    localparam logic [SUB_W-1:0] SUB_MID   = SUB_W'(WIDTH);
    localparam logic [SUB_W-1:0] SUB_LAST  = SUB_W'(WIDTH + 1);
    localparam logic [SUB_W-1:0] SUB_SETUP = SUB_W'(SETUP_LEN - 1);
    localparam logic [SUB_W-1:0] SUB_WIN   = SUB_W'(WINDOW_LEN - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

    logic [6:0]          r_dev_addr;
    logic [1:0]          r_mode;
    logic                r_win;
    logic [PAGE_W-1:0]   r_page;
    logic [SUB_W-1:0]    r_sub;
    logic [STORE_AW-1:0] r_sweep;

    logic [STORE_AW-1:0] r_pix_addr;
    logic [7:0]          r_pix_mask;
    logic                r_pix_on;
    logic                r_pix_ok;

    logic                r_strobe;
    logic [7:0]          r_data;
    logic [6:0]          r_addr;
    logic                r_ms;
    logic                r_me;
    logic                r_se;

    logic [1:0]          n_mode;
    logic                n_win;
    logic [PAGE_W-1:0]   n_page;
    logic [SUB_W-1:0]    n_sub;
    logic [7:0]          n_data;
    logic                n_ms;
    logic                n_me;
    logic                n_se;

    logic [COL_W-1:0]    pop_col;
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;
    logic [7:0]          pix_byte;

    assign o_stat.active     = (r_mode != MODE_IDLE);
    assign o_stat.addr_ok    = (r_dev_addr >= ADDR_MIN) && (r_dev_addr <= ADDR_MAX);
    assign o_stat.sweep_last = (r_sweep == STORE_AW'(STORE_BYTES - 1));

    // last column of a page travels as a message of its own
    assign pop_col   = (r_sub == SUB_LAST) ? COL_W'(WIDTH - 1) : COL_W'(r_sub - SUB_W'(1));
    assign ram_re    = i_cmd.pix_rd | i_cmd.pop_rd;
    assign ram_raddr = i_cmd.pix_rd ? {i_row[5:3], i_column[6:0]} : {r_page, pop_col};

    assign pix_byte  = r_pix_on ? (ram_rdata | r_pix_mask) : (ram_rdata & ~r_pix_mask);
    assign ram_we    = i_cmd.sweep_wr | (i_cmd.pix_wr & r_pix_ok);
    assign ram_waddr = i_cmd.sweep_wr ? r_sweep : r_pix_addr;
    assign ram_wdata = i_cmd.sweep_wr ? 8'h00 : pix_byte;

    ofbf_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // framing and next position for the byte being popped
    always_comb begin
        n_mode = r_mode;
        n_win  = r_win;
        n_page = r_page;
        n_sub  = r_sub + SUB_W'(1);
        n_data = ram_rdata;
        n_ms   = 1'b0;
        n_me   = 1'b0;
        n_se   = 1'b0;
        if (r_mode == MODE_INIT) begin
            n_data = setup_byte(r_sub[4:0]);
            n_ms   = (r_sub == '0);
            n_me   = (r_sub == SUB_SETUP);
            n_se   = n_me;
            if (n_se) begin
                n_mode = MODE_IDLE;
                n_sub  = '0;
            end
        end else if (r_win) begin
            n_data = window_byte(r_sub[2:0]);
            n_ms   = (r_sub == '0);
            n_me   = (r_sub == SUB_WIN);
            if (n_me) begin
                n_win  = 1'b0;
                n_sub  = '0;
                n_page = '0;
            end
        end else begin
            n_ms = (r_sub == '0) || (r_sub == SUB_MID);
            n_me = (r_sub == SUB_MID - SUB_W'(1)) || (r_sub == SUB_LAST);
            n_se = (r_sub == SUB_LAST) && (r_page == PAGE_LAST);
            if (n_ms) begin
                n_data = DATA_PREFIX;
            end
            if (r_sub == SUB_LAST) begin
                n_sub  = '0;
                n_page = r_page + PAGE_W'(1);
                if (n_se) begin
                    n_mode = MODE_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
            r_mode     <= MODE_IDLE;
            r_win      <= 1'b0;
            r_page     <= '0;
            r_sub      <= '0;
            r_sweep    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_wdata;
            end
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_wr) begin
                r_sweep <= r_sweep + STORE_AW'(1);
            end
            if (i_cmd.start_init) begin
                r_mode <= MODE_INIT;
                r_win  <= 1'b0;
                r_sub  <= '0;
                r_page <= '0;
            end else if (i_cmd.start_present) begin
                r_mode <= MODE_PRESENT;
                r_win  <= 1'b1;
                r_sub  <= '0;
                r_page <= '0;
            end else if (i_cmd.pop_emit) begin
                r_mode <= n_mode;
                r_win  <= n_win;
                r_sub  <= n_sub;
                r_page <= n_page;
            end
            r_strobe <= i_cmd.pop_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_rd) begin
            r_pix_addr <= {i_row[5:3], i_column[6:0]};
            r_pix_mask <= 8'(1) << i_row[2:0];
            r_pix_on   <= i_pixel_on;
            r_pix_ok   <= !i_column[7] && (i_row[7:6] == 2'b00);
        end
        if (i_cmd.pop_emit) begin
            r_data <= n_data;
            r_addr <= r_dev_addr;
            r_ms   <= n_ms;
            r_me   <= n_me;
            r_se   <= n_se;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_data_byte     = r_data;
    assign o_bus_address   = r_addr;
    assign o_message_start = r_ms;
    assign o_message_end   = r_me;
    assign o_stream_end    = r_se;

endmodule
`default_nettype wire

>>> src/oled_framebuffer_flush_engine_top.sv
// top level: page frame store with bus byte streamer for a 128x64 display
// a next-byte transfer reads the store on acceptance, emits in the pop state, then registers its result strobe
// pixel and next-byte items each run a read step, then a write or emit step; busy blocks new items meanwhile
// clear and a valid init hold busy while the store is swept, one store byte zeroed per cycle
// reset: synchronous active low; busy stays high for the store sweep after reset
// results cannot be stalled by the receiver; each strobe lasts exactly one cycle
`default_nettype none
module oled_framebuffer_flush_engine_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_operation,
    input  wire logic [7:0] i_column,
    input  wire logic [7:0] i_row,
    input  wire logic       i_pixel_on,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    output logic            o_result_strobe,
    output logic [7:0]      o_data_byte,
    output logic [6:0]      o_bus_address,
    output logic            o_message_start,
    output logic            o_message_end,
    output logic            o_stream_end
);
    import ofbf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ofbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    ofbf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_pixel_on      (i_pixel_on),
        .o_result_strobe (o_result_strobe),
        .o_data_byte     (o_data_byte),
        .o_bus_address   (o_bus_address),
        .o_message_start (o_message_start),
        .o_message_end   (o_message_end),
        .o_stream_end    (o_stream_end)
    );

`ifndef SYNTHESIS
    // a result always comes out of the pop cycle
    a_strobe_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(cmd.pop_emit))
        else $error("result strobe without a pop");

    // stream end always closes a message
    a_stream_end_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_stream_end) |-> o_message_end)
        else $error("stream end on a byte that does not end a message");

    // every message is at least two bytes long
    a_no_single_byte_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !(o_message_start && o_message_end))
        else $error("message starts and ends on the same byte");

    // after the last byte the stream is idle again
    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_stream_end) |-> !stat.active)
        else $error("stream still active after its final byte");
`endif

endmodule
`default_nettype wire
